FILE: src/slsort_pkg.sv
`default_nettype none
package slsort_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // one classified request as it travels from front to back
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
    logic                         keep;   // fits in the store
    logic                         drop;   // list has lost a value so far
  } item_t;

endpackage
`default_nettype wire

FILE: src/slsort_front.sv
`default_nettype none
module slsort_front (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire signed [slsort_pkg::DATA_WIDTH-1:0] in_value,
  input  wire                                 in_last,
  output logic                                push,
  output slsort_pkg::item_t                   push_item,
  input  wire                                 q_full
);
  import slsort_pkg::*;

  logic [CNT_W-1:0] count;
  logic             dropped;
  logic             keep;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign keep     = count < CNT_W'(DEPTH);

  assign push            = accept;
  assign push_item.value = in_value;
  assign push_item.last  = in_last;
  assign push_item.keep  = keep;
  assign push_item.drop  = dropped || !keep;

  // track list fill so every request leaves already classified
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        count   <= '0;
        dropped <= 1'b0;
      end else begin
        if (keep) begin
          count <= count + CNT_W'(1);
        end
        dropped <= dropped || !keep;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/slsort_queue.sv
`default_nettype none
module slsort_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  wire slsort_pkg::item_t push_item,
  output logic               full,
  output logic               not_empty,
  input  wire                pop,
  output slsort_pkg::item_t  pop_item
);
  import slsort_pkg::*;

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full      = fill == QCNT_W'(QDEPTH);
  assign not_empty = fill != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/slsort_back.sv
`default_nettype none
module slsort_back (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  q_not_empty,
  output logic                                 pop,
  input  wire slsort_pkg::item_t               pop_item,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [slsort_pkg::DATA_WIDTH-1:0] out_value,
  output logic                                 out_last,
  output logic                                 out_overflow
);
  import slsort_pkg::*;

  typedef enum logic [2:0] {
    COLLECT = 3'b001,
    SORT    = 3'b010,
    EMIT    = 3'b100
  } state_t;

  state_t                       state;
  logic signed [DATA_WIDTH-1:0] store      [DEPTH];
  logic signed [DATA_WIDTH-1:0] store_next [DEPTH];
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             remaining;
  logic [IDX_W-1:0]             pass;
  logic                         overflow;
  logic                         take;
  logic                         emit;

  assign pop          = (state == COLLECT) && q_not_empty;
  assign take         = pop;
  assign emit         = (state == EMIT) && out_ready;
  assign out_valid    = state == EMIT;
  assign out_value    = store[0];
  assign out_last     = remaining == CNT_W'(1);
  assign out_overflow = overflow;

  // one odd-even compare-exchange pass over the held entries
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      store_next[k] = store[k];
    end
    for (int k = 0; k < DEPTH - 1; k++) begin
      if ((pass[0] == 1'(k % 2)) && (CNT_W'(k + 1) < remaining) &&
          (store[k] > store[k + 1])) begin
        store_next[k]     = store[k + 1];
        store_next[k + 1] = store[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      COLLECT: begin
        if (take && pop_item.keep) begin
          store[count[IDX_W-1:0]] <= pop_item.value;
        end
      end
      SORT: begin
        for (int k = 0; k < DEPTH; k++) begin
          store[k] <= store_next[k];
        end
      end
      EMIT: begin
        // advance the sorted list toward the output slot
        if (emit) begin
          for (int k = 0; k < DEPTH - 1; k++) begin
            store[k] <= store[k + 1];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= COLLECT;
      count     <= '0;
      remaining <= '0;
      pass      <= '0;
      overflow  <= 1'b0;
    end else begin
      case (state)
        COLLECT: begin
          if (take) begin
            if (pop_item.last) begin
              remaining <= count + CNT_W'(pop_item.keep);
              overflow  <= pop_item.drop;
              count     <= '0;
              pass      <= '0;
              state     <= SORT;
            end else if (pop_item.keep) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        SORT: begin
          if (pass == IDX_W'(DEPTH - 1)) begin
            state <= EMIT;
          end else begin
            pass <= pass + IDX_W'(1);
          end
        end
        EMIT: begin
          if (emit) begin
            remaining <= remaining - CNT_W'(1);
            if (remaining == CNT_W'(1)) begin
              state <= COLLECT;
            end
          end
        end
        default: begin
          state <= COLLECT;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/signed_list_sorter.sv
// The last item of a list passes the queue to the back end; SORT runs the odd-even
// compare-exchange pass loop, then m_tvalid rises in EMIT. Items enter at one per cycle
// while a list collects and the queue has room; results leave at one per cycle with
// m_tready high. A two-entry queue lets the next list start entering as results drain.
// Reset clears list counts, queue and state; stored values stay undefined until written.
`default_nettype none
module signed_list_sorter (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire signed [slsort_pkg::DATA_WIDTH-1:0] s_tdata,  // value
  input  wire                                  s_tlast,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic signed [slsort_pkg::DATA_WIDTH-1:0] m_tdata, // sorted_value
  output logic                                 m_tlast,
  output logic                                 m_tuser   // overflow
);
  import slsort_pkg::*;

  item_t push_item;
  item_t pop_item;
  logic  push;
  logic  q_full;
  logic  q_not_empty;
  logic  pop;

  slsort_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_value  (s_tdata),
    .in_last   (s_tlast),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  slsort_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  slsort_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .pop          (pop),
    .pop_item     (pop_item),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_value    (m_tdata),
    .out_last     (m_tlast),
    .out_overflow (m_tuser)
  );

endmodule
`default_nettype wire

FILE: tb/sv/tb_signed_list_sorter.sv
`timescale 1ns / 1ps
module tb_signed_list_sorter;
  import slsort_pkg::*;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;

  typedef struct packed {
    elem_t value;
    logic  last;
    logic  overflow;
  } sorted_t;

  localparam int    QUIET_LIMIT  = 2000;
  localparam int    RANDOM_ITEMS = 480;
  localparam elem_t MIN_VAL      = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam elem_t MAX_VAL      = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic  clk      = 1'b0;
  logic  rst      = 1'b1;
  logic  s_tvalid = 1'b0;
  logic  s_tready;
  elem_t s_tdata  = '0;
  logic  s_tlast  = 1'b0;
  logic  m_tvalid;
  logic  m_tready = 1'b0;
  elem_t m_tdata;
  logic  m_tlast;
  logic  m_tuser;

  // values of the open list and whether any were lost
  elem_t       held_values[$];
  bit          list_dropped = 1'b0;
  sorted_t     sorted_expect[$];
  sorted_t     want;
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  bit          bursty       = 1'b0;
  int          burst_left   = 0;
  logic [4:0]  stall_phase  = '0;
  logic [31:0] stall_mask   = '1;

  signed_list_sorter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Store the value, or drop it when full; on close, sort and queue the results.
  task automatic predict_sorted_list(input elem_t v, input bit closes);
    elem_t t;
    int    n;
    if (held_values.size() < DEPTH) held_values.push_back(v);
    else list_dropped = 1'b1;
    if (closes) begin
      n = held_values.size();
      for (int p = 0; p + 1 < n; p++) begin
        for (int k = 0; k + 1 < n - p; k++) begin
          if (held_values[k] > held_values[k+1]) begin
            t                = held_values[k];
            held_values[k]   = held_values[k+1];
            held_values[k+1] = t;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        sorted_expect.push_back(sorted_t'{held_values[k], k == n - 1, list_dropped});
      end
      held_values.delete();
      list_dropped = 1'b0;
    end
  endtask

  // Call right after a rising edge; returns right after the accepting edge.
  task automatic send_item(input elem_t v, input bit closes);
    if (bursty && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= closes;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    if (burst_left > 0) burst_left--;
    predict_sorted_list(v, closes);
  endtask

  task automatic test_single_elements();
    bursty = 1'b0;
    send_item(MIN_VAL, 1'b1);
    send_item(MAX_VAL, 1'b1);
  endtask

  // Fill the store, then close with a value that no longer fits.
  task automatic test_store_overflow();
    elem_t vals [17] = '{MAX_VAL, MIN_VAL, 0, -1, 1, elem_t'(32'h5555_5555),
                         elem_t'(32'hAAAA_AAAA), MAX_VAL, MIN_VAL, 7, -7, 0, 100, -100,
                         elem_t'(32'h7FFF_0000), elem_t'(32'h8000_FFFF), 42};
    bursty = 1'b0;
    foreach (vals[i]) send_item(vals[i], i == 16);
  endtask

  task automatic test_duplicates();
    elem_t vals [4] = '{3, 3, -3, 3};
    bursty = 1'b1;
    foreach (vals[i]) send_item(vals[i], i == 3);
  endtask

  task automatic test_random_lists();
    int    sent;
    int    len;
    int    style;
    elem_t v;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = DEPTH + $urandom_range(1, 4);
        1:       len = DEPTH;
        default: len = $urandom_range(1, DEPTH);
      endcase
      style  = $urandom_range(0, 3);
      bursty = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < len; i++) begin
        case (style)
          0: v = $urandom_range(0, 8) - 4;
          1: begin
            case ($urandom_range(0, 3))
              0:       v = MIN_VAL;
              1:       v = MAX_VAL;
              2:       v = 0;
              default: v = $urandom;
            endcase
          end
          default: v = $urandom;
        endcase
        send_item(v, i == len - 1);
      end
      sent += len;
    end
  endtask

  // Receiver stalls follow a mask that is redrawn each time the 5-bit stall phase wraps.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (stall_phase == '1) stall_mask <= ($urandom_range(0, 2) == 0) ? '1 : $urandom;
    m_tready <= stall_mask[stall_phase];
  end

  // Inputs only move at the rising edge, so the negedge view is what the next edge takes.
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (sorted_expect.size() == 0) begin
        $error("unexpected result: sorted_value %0d", m_tdata);
        mismatches++;
      end else begin
        want = sorted_expect.pop_front();
        if (m_tdata !== want.value) begin
          $error("sorted_value: expected %0d, got %0d", want.value, m_tdata);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last_out: expected %0b, got %0b", want.last, m_tlast);
          mismatches++;
        end
        if (m_tuser !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, m_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_single_elements();
    test_store_overflow();
    test_duplicates();
    test_random_lists();
    s_tvalid <= 1'b0;
    wait (sorted_expect.size() == 0);
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && sorted_expect.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/slsort_pkg.sv
src/slsort_front.sv
src/slsort_queue.sv
src/slsort_back.sv
src/signed_list_sorter.sv
tb/sv/tb_signed_list_sorter.sv
